/* rtl/core/assert_macros.svh */
// Assertion macros shared by the H-bridge sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while aresetn is low.
`define HBSQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Condition that must never be seen at a clock edge.
`define HBSQ_NEVER(lbl, cond, msg) \
    `HBSQ_ASSERT(lbl, !(cond), msg)

`endif

/* rtl/core/hbsq_pkg.sv */
// Shared types, codes and constants of the H-bridge actuator test sequencer.
`timescale 1ns / 1ps

package hbsq_pkg;

    localparam int TIME_BITS_DEF  = 32;
    localparam int SENSE_BITS_DEF = 12;

    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 4;
    localparam int M_TDATA_W  = 120;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    // register reset values
    localparam logic [7:0]  CEILING_RST = 8'd190;
    localparam logic [31:0] GUARD_RST   = 32'd20000;
    localparam logic [15:0] STEP_RST    = 16'd250;

    localparam logic [9:0] FULL_SCALE     = 10'd1000;
    localparam logic [9:0] STOP_THRESHOLD = 10'd20;

    // floor(x / 1000) == (x * DUTY_RECIP) >> DUTY_SHIFT, exact for x < 2^18
    localparam logic [18:0] DUTY_RECIP = 19'd268436;
    localparam int          DUTY_SHIFT = 28;
    // floor(raw * 3300 / 4095) == (raw * MV_RECIP) >> MV_SHIFT, exact for raw < 2^12
    localparam logic [28:0] MV_RECIP = 29'd432643420;
    localparam int          MV_SHIFT = 29;

    typedef enum logic [3:0] {
        OP_TICK     = 4'd0,
        OP_APPLY    = 4'd1,
        OP_RELEASE  = 4'd2,
        OP_STOP     = 4'd3,
        OP_REVERSE  = 4'd4,
        OP_SEARCH   = 4'd5,
        OP_MOVED    = 4'd6,
        OP_STROKE   = 4'd7,
        OP_STALLED  = 4'd8,
        OP_SENSE    = 4'd9,
        OP_CLEAR    = 4'd10
    } op_t;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_GUARD     = 3'd1,
        EV_CEILING   = 3'd2,
        EV_MIN_FOUND = 3'd3,
        EV_STROKE    = 3'd4
    } ev_t;

    typedef enum logic [1:0] {
        DIR_STOP    = 2'd0,
        DIR_APPLY   = 2'd1,
        DIR_RELEASE = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        CFG_CEILING = 2'd0,
        CFG_GUARD   = 2'd1,
        CFG_STEP    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]  duty_ceiling;
        logic [31:0] guard_ms;
        logic [15:0] search_step_ms;
    } cfg_t;

    // s_tdata layout, last field lowest
    typedef struct packed {
        logic [5:0]  pad;
        logic [11:0] left_sense;
        logic [11:0] right_sense;
        logic [9:0]  magnitude;
    } in_t;

    // registered item with its pre-computed products
    typedef struct packed {
        logic [3:0]  op;
        logic [9:0]  mag;
        logic [17:0] scaled;
        logic [11:0] right_raw;
        logic [11:0] left_raw;
        logic [11:0] right_mv;
        logic [11:0] left_mv;
    } item_t;

    // m_tdata layout, last field lowest
    typedef struct packed {
        logic [4:0]         pad;
        logic [2:0]         event_code;
        logic [15:0]        stroke_elapsed_ms;
        logic [15:0]        stroke_time_ms;
        logic [7:0]         found_duty;
        logic [7:0]         min_duty_report;
        logic [11:0]        current_peak;
        logic [11:0]        current_mv;
        logic [11:0]        current_raw;
        logic               reversed;
        logic signed [10:0] command_permille;
        logic [7:0]         left_duty;
        logic [7:0]         right_duty;
    } out_t;

endpackage

/* rtl/core/hbridge_actuator_test_sequencer_core.sv */
// Top level of the H-bridge actuator test sequencer.
`timescale 1ns / 1ps

//  channel | ports                          | contents
//  --------+--------------------------------+------------------------------------------
//  input   | s_tvalid s_tready s_tdata/user | one command or 1 ms tick per transfer
//  result  | m_tvalid m_tready m_tdata      | one status item per accepted input transfer
//  config  | cfg_wr_en cfg_addr cfg_wr_data | duty ceiling, guard time, search step
//
// Every input transfer yields exactly one result transfer, through two registers in order:
// the input register (magnitude*ceiling and sense-to-mV products), then the state update
// ending in the result register. One transfer per cycle sustained while m_tready is high.
// A stall on m_tready holds the result register; the input register still takes one more
// transfer before s_tready drops. Reset (aresetn low, synchronous) clears the valid flags
// and all sequencer state and loads the register defaults; no clearing pass is needed.

module hbridge_actuator_test_sequencer_core #(
    parameter int TIME_BITS  = hbsq_pkg::TIME_BITS_DEF,
    parameter int SENSE_BITS = hbsq_pkg::SENSE_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: magnitude[9:0], right_sense[21:10], left_sense[33:22], zero fill
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [hbsq_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: operation[3:0]
    input  logic [hbsq_pkg::S_TUSER_W-1:0]   s_tuser,
    // m_tdata: right_duty[7:0], left_duty[15:8], command_permille[26:16], reversed[27],
    //          current_raw[39:28], current_mv[51:40], current_peak[63:52],
    //          min_duty_report[71:64], found_duty[79:72], stroke_time_ms[95:80],
    //          stroke_elapsed_ms[111:96], event_code[114:112], zero fill
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [hbsq_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [hbsq_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [hbsq_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import hbsq_pkg::*;

    cfg_t  cfg;
    item_t item;
    logic  item_valid;
    logic  item_take;
    out_t  mon;
    logic  both_driven;
    logic  guard_ev;
    logic  guard_clean;
    logic  found_ev;
    logic  found_match;

    hbsq_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // input register; s_tready is high while the register is empty or the engine takes the held item
    hbsq_in_stage #(
        .SENSE_BITS (SENSE_BITS)
    ) u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // state update plus result register
    hbsq_engine #(
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    assign mon = out_t'(m_tdata);

    assign both_driven = m_tvalid && mon.right_duty != '0 && mon.left_duty != '0;
    assign guard_ev    = m_tvalid && mon.event_code == EV_GUARD;
    assign guard_clean = mon.right_duty == '0 && mon.left_duty == '0 &&
                         mon.command_permille == '0;
    assign found_ev    = m_tvalid && mon.event_code == EV_MIN_FOUND;
    assign found_match = mon.min_duty_report == mon.found_duty;

    `include "assert_macros.svh"

    // only one half bridge may carry duty
    `HBSQ_NEVER(a_one_side, both_driven, "both half bridges driven")
    // a guard trip leaves the bridge stopped and the command cleared
    `HBSQ_ASSERT(a_guard_stop, guard_ev |-> guard_clean, "guard trip left drive active")
    // once the minimum is found the report shows the latched duty
    `HBSQ_ASSERT(a_found_report, found_ev |-> found_match, "search still reported after minimum found")

endmodule

/* rtl/core/hbsq_cfg_regs.sv */
// Configuration register file of the H-bridge sequencer.
`timescale 1ns / 1ps

module hbsq_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [hbsq_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [hbsq_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output hbsq_pkg::cfg_t                   cfg
);
    import hbsq_pkg::*;

    cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_CEILING: cfg_next.duty_ceiling   = cfg_wr_data[7:0];
                CFG_GUARD:   cfg_next.guard_ms       = cfg_wr_data[31:0];
                CFG_STEP:    cfg_next.search_step_ms = cfg_wr_data[15:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.duty_ceiling   <= CEILING_RST;
            cfg_reg.guard_ms       <= GUARD_RST;
            cfg_reg.search_step_ms <= STEP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/hbsq_in_stage.sv */
// Input register of the H-bridge sequencer, with magnitude and sense pre-scaling.
`timescale 1ns / 1ps

module hbsq_in_stage #(
    parameter int SENSE_BITS = hbsq_pkg::SENSE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  hbsq_pkg::cfg_t                  cfg,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hbsq_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [hbsq_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            item_valid,
    output hbsq_pkg::item_t                 item,
    input  logic                            item_take
);
    import hbsq_pkg::*;

    localparam logic [11:0] SENSE_MASK = 12'((33'd1 << SENSE_BITS) - 33'd1);

    in_t         din;
    item_t       item_reg, item_next;
    logic        valid_reg, valid_next;
    logic        s_accept;
    logic [9:0]  mag_sat;
    logic [11:0] r_raw, l_raw;

    assign din      = in_t'(s_tdata);
    assign s_tready = !valid_reg || item_take;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        mag_sat = din.magnitude;
        if (din.magnitude == '0 || din.magnitude > FULL_SCALE) begin
            mag_sat = FULL_SCALE;
        end
        r_raw = din.right_sense & SENSE_MASK;
        l_raw = din.left_sense & SENSE_MASK;

        item_next.op        = s_tuser;
        item_next.mag       = mag_sat;
        item_next.scaled    = 18'(mag_sat) * 18'(cfg.duty_ceiling);
        item_next.right_raw = r_raw;
        item_next.left_raw  = l_raw;
        item_next.right_mv  = 12'((41'(r_raw) * 41'(MV_RECIP)) >> MV_SHIFT);
        item_next.left_mv   = 12'((41'(l_raw) * 41'(MV_RECIP)) >> MV_SHIFT);

        if (s_accept) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_accept) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/core/hbsq_engine.sv */
// State update and result register of the H-bridge sequencer.
`timescale 1ns / 1ps

module hbsq_engine #(
    parameter int TIME_BITS = hbsq_pkg::TIME_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  hbsq_pkg::cfg_t                  cfg,
    input  logic                            item_valid,
    input  hbsq_pkg::item_t                 item,
    output logic                            item_take,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hbsq_pkg::M_TDATA_W-1:0]  m_tdata
);
    import hbsq_pkg::*;

    localparam int TW = TIME_BITS;
    localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic [TW-1:0]      time_reg, time_next;
    logic               driving_reg, driving_next;
    logic [TW-1:0]      dstart_reg, dstart_next;
    dir_t               dir_reg, dir_next;
    logic [7:0]         duty_reg, duty_next;
    logic signed [10:0] cmd_reg, cmd_next;
    logic               rev_reg, rev_next;
    logic               sense_en_reg, sense_en_next;
    logic [11:0]        raw_reg, raw_next;
    logic [11:0]        mv_reg, mv_next;
    logic [11:0]        peak_reg, peak_next;
    logic               search_reg, search_next;
    logic [7:0]         sduty_reg, sduty_next;
    logic [7:0]         minf_reg, minf_next;
    logic [TW-1:0]      sstamp_reg, sstamp_next;
    logic               stroke_reg, stroke_next;
    logic [TW-1:0]      sstart_reg, sstart_next;
    logic [15:0]        stime_reg, stime_next;
    logic               out_valid_reg, out_valid_next;
    out_t               out_reg, out_next;

    logic               consume;
    ev_t                ev;
    logic [TW-1:0]      t1;
    logic [TW-1:0]      drive_age;
    logic [7:0]         cmd_duty;
    logic [11:0]        sample;

    assign item_take = !out_valid_reg || m_tready;
    assign consume   = item_valid && item_take;
    assign t1        = time_reg + 1'b1;
    assign cmd_duty  = 8'((37'(item.scaled) * 37'(DUTY_RECIP)) >> DUTY_SHIFT);

    always_comb begin
        time_next     = time_reg;
        driving_next  = driving_reg;
        dstart_next   = dstart_reg;
        dir_next      = dir_reg;
        duty_next     = duty_reg;
        cmd_next      = cmd_reg;
        rev_next      = rev_reg;
        sense_en_next = sense_en_reg;
        raw_next      = raw_reg;
        mv_next       = mv_reg;
        peak_next     = peak_reg;
        search_next   = search_reg;
        sduty_next    = sduty_reg;
        minf_next     = minf_reg;
        sstamp_next   = sstamp_reg;
        stroke_next   = stroke_reg;
        sstart_next   = sstart_reg;
        stime_next    = stime_reg;
        ev            = EV_NONE;
        sample        = item.right_raw;
        drive_age     = '0;

        unique case (item.op)
            OP_TICK: begin
                time_next = t1;
                // search ramp step
                if (search_reg && (t1 - sstamp_reg) >= TW'(cfg.search_step_ms)) begin
                    sstamp_next = t1;
                    if (sduty_reg < cfg.duty_ceiling) begin
                        sduty_next   = sduty_reg + 1'b1;
                        duty_next    = sduty_reg + 1'b1;
                        dir_next     = rev_reg ? DIR_RELEASE : DIR_APPLY;
                        driving_next = 1'b1;
                        dstart_next  = t1;
                    end else begin
                        search_next  = 1'b0;
                        dir_next     = DIR_STOP;
                        duty_next    = '0;
                        driving_next = 1'b0;
                        ev           = EV_CEILING;
                    end
                end
                // watchdog, idle while searching; age wraps at the time width
                drive_age = t1 - dstart_next;
                if (driving_next && !search_next &&
                    CW'(drive_age) >= CW'(cfg.guard_ms)) begin
                    dir_next     = DIR_STOP;
                    duty_next    = '0;
                    driving_next = 1'b0;
                    cmd_next     = '0;
                    stroke_next  = 1'b0;
                    ev           = EV_GUARD;
                end
                // sense sample of the driven side, right side when stopped; zero while sensing is off
                if (!sense_en_reg) begin
                    raw_next = '0;
                    mv_next  = '0;
                end else begin
                    if (dir_next == DIR_RELEASE) begin
                        sample  = item.left_raw;
                        mv_next = item.left_mv;
                    end else begin
                        sample  = item.right_raw;
                        mv_next = item.right_mv;
                    end
                    raw_next = sample;
                    if (sample > peak_reg) begin
                        peak_next = sample;
                    end
                end
            end
            OP_APPLY, OP_RELEASE: begin
                search_next = 1'b0;
                stroke_next = 1'b0;
                if (item.mag <= STOP_THRESHOLD) begin
                    dir_next     = DIR_STOP;
                    duty_next    = '0;
                    driving_next = 1'b0;
                end else begin
                    dir_next     = ((item.op == OP_APPLY) ^ rev_reg) ? DIR_APPLY : DIR_RELEASE;
                    duty_next    = cmd_duty;
                    driving_next = 1'b1;
                    dstart_next  = time_reg;
                end
                cmd_next = (item.op == OP_APPLY) ? $signed({1'b0, item.mag})
                                                 : -$signed({1'b0, item.mag});
            end
            OP_STOP: begin
                search_next  = 1'b0;
                stroke_next  = 1'b0;
                dir_next     = DIR_STOP;
                duty_next    = '0;
                driving_next = 1'b0;
                cmd_next     = '0;
            end
            OP_REVERSE: begin
                rev_next     = !rev_reg;
                dir_next     = DIR_STOP;
                duty_next    = '0;
                driving_next = 1'b0;
            end
            OP_SEARCH: begin
                search_next = 1'b1;
                stroke_next = 1'b0;
                sduty_next  = '0;
                minf_next   = '0;
                sstamp_next = time_reg;
            end
            OP_MOVED: begin
                if (search_reg) begin
                    minf_next    = sduty_reg;
                    search_next  = 1'b0;
                    dir_next     = DIR_STOP;
                    duty_next    = '0;
                    driving_next = 1'b0;
                    ev           = EV_MIN_FOUND;
                end
            end
            OP_STROKE: begin
                search_next  = 1'b0;
                stroke_next  = 1'b1;
                sstart_next  = time_reg;
                stime_next   = '0;
                peak_next    = '0;
                dir_next     = rev_reg ? DIR_RELEASE : DIR_APPLY;
                duty_next    = cfg.duty_ceiling;
                driving_next = 1'b1;
                dstart_next  = time_reg;
            end
            OP_STALLED: begin
                if (stroke_reg) begin
                    stime_next   = 16'(time_reg - sstart_reg);
                    stroke_next  = 1'b0;
                    dir_next     = DIR_STOP;
                    duty_next    = '0;
                    driving_next = 1'b0;
                    ev           = EV_STROKE;
                end
            end
            OP_SENSE: begin
                sense_en_next = !sense_en_reg;
                peak_next     = '0;
            end
            OP_CLEAR: begin
                peak_next  = '0;
                stime_next = '0;
                minf_next  = '0;
            end
            default: begin
            end
        endcase

        out_next.pad               = '0;
        out_next.event_code        = ev;
        out_next.stroke_elapsed_ms = stroke_next ? 16'(time_next - sstart_next) : '0;
        out_next.stroke_time_ms    = stime_next;
        out_next.found_duty        = minf_next;
        out_next.min_duty_report   = search_next ? sduty_next : minf_next;
        out_next.current_peak      = peak_next;
        out_next.current_mv        = mv_next;
        out_next.current_raw       = raw_next;
        out_next.reversed          = rev_next;
        out_next.command_permille  = cmd_next;
        out_next.left_duty         = (dir_next == DIR_RELEASE) ? duty_next : '0;
        out_next.right_duty        = (dir_next == DIR_APPLY) ? duty_next : '0;

        if (consume) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg      <= '0;
            driving_reg   <= 1'b0;
            dstart_reg    <= '0;
            dir_reg       <= DIR_STOP;
            duty_reg      <= '0;
            cmd_reg       <= '0;
            rev_reg       <= 1'b0;
            sense_en_reg  <= 1'b0;
            raw_reg       <= '0;
            mv_reg        <= '0;
            peak_reg      <= '0;
            search_reg    <= 1'b0;
            sduty_reg     <= '0;
            minf_reg      <= '0;
            sstamp_reg    <= '0;
            stroke_reg    <= 1'b0;
            sstart_reg    <= '0;
            stime_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (consume) begin
                time_reg     <= time_next;
                driving_reg  <= driving_next;
                dstart_reg   <= dstart_next;
                dir_reg      <= dir_next;
                duty_reg     <= duty_next;
                cmd_reg      <= cmd_next;
                rev_reg      <= rev_next;
                sense_en_reg <= sense_en_next;
                raw_reg      <= raw_next;
                mv_reg       <= mv_next;
                peak_reg     <= peak_next;
                search_reg   <= search_next;
                sduty_reg    <= sduty_next;
                minf_reg     <= minf_next;
                sstamp_reg   <= sstamp_next;
                stroke_reg   <= stroke_next;
                sstart_reg   <= sstart_next;
                stime_reg    <= stime_next;
            end
        end
        if (consume) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule
